// ===== hw/rtl/imutg_pkg.sv =====
// ----------------------------------------------------------------------------
// imutg_pkg
// Shared types, constants and the arctangent table of the IMU tilt and gyro
// angle integrator.
// ----------------------------------------------------------------------------
package imutg_pkg;

   // Angles are carried in degrees Q16 at 57.3 degrees per radian.
   localparam int ANGLE_W         = 27;
   localparam int ANGLE_TABLE_LEN = 24;
   localparam int ITER_W          = 5;
   localparam logic signed [ANGLE_W-1:0] HALF_TURN_Q16   = 27'sd11797349;
   localparam logic signed [ANGLE_W-1:0] ACCEL_OUT_LIMIT = 27'sd46083;

   // Gyro increment is (|rate| * dt * 512 + 64062) / 128125. The quotient is
   // estimated by a reciprocal multiplication on the upper dividend bits, which
   // falls short by at most two; two compare and subtract steps finish it.
   localparam int DIV_STEPS = 4;
   localparam int QUO_W     = 28;
   localparam int REM_W     = 19;
   localparam int DVD_W     = 45;
   localparam int DVD_LOW   = 14;
   localparam int EST_W     = 61;
   localparam int EST_SHIFT = 32;
   localparam logic [17:0] GYRO_DIVISOR = 18'd128125;
   localparam logic [29:0] GYRO_RECIP   = 30'd549219466;
   localparam logic [DVD_W-1:0] GYRO_ROUND = 45'd64062;

   // Divider steps, by iteration count.
   localparam logic [ITER_W-1:0] DIV_ESTIMATE  = 5'd0;
   localparam logic [ITER_W-1:0] DIV_REMAINDER = 5'd1;
   localparam logic [ITER_W-1:0] DIV_FIX_A     = 5'd2;
   localparam logic [ITER_W-1:0] DIV_FIX_B     = 5'd3;

   // One accepted IMU sample.
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
      logic signed [15:0] gyro_z;
      logic [19:0]        dt_us;
   } sample_type;

   // Control from the sequencer to the arithmetic units.
   typedef struct packed {
      logic              load;
      logic              run;
      logic [ITER_W-1:0] iter;
      logic              commit;
   } ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_COMMIT,
      ST_DONE
   } st_type;

   // Arctangent of 2^-i in degrees Q16.
   function automatic logic signed [ANGLE_W-1:0] angle_entry(input logic [ITER_W-1:0] idx);
      logic signed [ANGLE_W-1:0] v;
      case (idx)
         5'd0:    v = 27'sd2949337;
         5'd1:    v = 27'sd1741095;
         5'd2:    v = 27'sd919947;
         5'd3:    v = 27'sd466979;
         5'd4:    v = 27'sd234396;
         5'd5:    v = 27'sd117312;
         5'd6:    v = 27'sd58670;
         5'd7:    v = 27'sd29337;
         5'd8:    v = 27'sd14669;
         5'd9:    v = 27'sd7334;
         5'd10:   v = 27'sd3667;
         5'd11:   v = 27'sd1834;
         5'd12:   v = 27'sd917;
         5'd13:   v = 27'sd458;
         5'd14:   v = 27'sd229;
         5'd15:   v = 27'sd115;
         5'd16:   v = 27'sd57;
         5'd17:   v = 27'sd29;
         5'd18:   v = 27'sd14;
         5'd19:   v = 27'sd7;
         5'd20:   v = 27'sd4;
         5'd21:   v = 27'sd2;
         5'd22:   v = 27'sd1;
         default: v = 27'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== hw/rtl/imutg_front.sv =====
// ----------------------------------------------------------------------------
// imutg_front
// Input side: accepts samples into a two-entry queue that the back end drains.
// ----------------------------------------------------------------------------
module imutg_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  imutg_pkg::sample_type req_item,
   output logic                  head_valid,
   output imutg_pkg::sample_type head_item,
   input  logic                  pop
);

   imutg_pkg::sample_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // Queue status and pointer updates.
   always_comb begin
      req_ready  = (count_ff != 2'd2);
      head_valid = (count_ff != 2'd0);
      head_item  = slot_ff[rd_ptr_ff];
      push       = req_valid && req_ready;
      wr_ptr_in  = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

// ===== hw/rtl/imutg_cordic.sv =====
// ----------------------------------------------------------------------------
// imutg_cordic
// Vectoring CORDIC for atan2(y, x), one rotation a cycle, result in degrees Q8.
// ----------------------------------------------------------------------------
module imutg_cordic #(
   parameter int STEPS = 16
) (
   input  logic                clock,
   input  imutg_pkg::ctl_type  ctl,
   input  logic signed [16:0]  opd_y,
   input  logic signed [15:0]  opd_x,
   output logic signed [16:0]  angle
);

   localparam int STEPS_EFF = (STEPS > imutg_pkg::ANGLE_TABLE_LEN) ?
                              imutg_pkg::ANGLE_TABLE_LEN : STEPS;

   logic signed [imutg_pkg::ANGLE_W-1:0] x_ff, x_in, y_ff, y_in, ang_ff, ang_in;
   logic signed [imutg_pkg::ANGLE_W-1:0] xs, ys, rnd, rq;
   logic signed [16:0] res_ff, res_in, x17, y17;
   logic               zero_ff, zero_in, xneg_ff, xneg_in, xneg;

   // Load pre-rotates, each run cycle rotates once, commit rounds and clamps.
   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      ang_in  = ang_ff;
      zero_in = zero_ff;
      xneg_in = xneg_ff;
      res_in  = res_ff;
      xs      = x_ff >>> ctl.iter;
      ys      = y_ff >>> ctl.iter;
      rnd     = ang_ff + (ang_ff[imutg_pkg::ANGLE_W-1] ? 27'sd127 : 27'sd128);
      rq      = rnd >>> 8;
      xneg    = opd_x[15];
      x17     = xneg ? -{opd_x[15], opd_x} : {opd_x[15], opd_x};
      y17     = xneg ? -opd_y : opd_y;
      if (ctl.load) begin
         x_in    = {{2{x17[16]}}, x17, 8'b0};
         y_in    = {{2{y17[16]}}, y17, 8'b0};
         zero_in = (opd_y == 17'sd0);
         xneg_in = xneg;
         if (xneg) begin
            ang_in = opd_y[16] ? -imutg_pkg::HALF_TURN_Q16 : imutg_pkg::HALF_TURN_Q16;
         end else begin
            ang_in = '0;
         end
      end else if (ctl.run && (ctl.iter < imutg_pkg::ITER_W'(STEPS_EFF))) begin
         if (!y_ff[imutg_pkg::ANGLE_W-1]) begin
            x_in   = x_ff + ys;
            y_in   = y_ff - xs;
            ang_in = ang_ff + imutg_pkg::angle_entry(ctl.iter);
         end else begin
            x_in   = x_ff - ys;
            y_in   = y_ff + xs;
            ang_in = ang_ff - imutg_pkg::angle_entry(ctl.iter);
         end
      end else if (ctl.commit) begin
         if (zero_ff) begin
            res_in = xneg_ff ? 17'(imutg_pkg::ACCEL_OUT_LIMIT) : 17'sd0;
         end else if (rq > imutg_pkg::ACCEL_OUT_LIMIT) begin
            res_in = 17'(imutg_pkg::ACCEL_OUT_LIMIT);
         end else if (rq < -imutg_pkg::ACCEL_OUT_LIMIT) begin
            res_in = -17'(imutg_pkg::ACCEL_OUT_LIMIT);
         end else begin
            res_in = rq[16:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      ang_ff  <= ang_in;
      zero_ff <= zero_in;
      xneg_ff <= xneg_in;
      res_ff  <= res_in;
   end

   assign angle = res_ff;

endmodule

// ===== hw/rtl/imutg_gyro.sv =====
// ----------------------------------------------------------------------------
// imutg_gyro
// One gyro axis: rate times elapsed time, divided down to degrees Q16 and
// added to a saturating accumulator; the angle is given in degrees Q8.
// ----------------------------------------------------------------------------
module imutg_gyro #(
   parameter int ACC_W = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  imutg_pkg::ctl_type  ctl,
   input  logic signed [15:0]  rate,
   input  logic [19:0]         dt,
   output logic signed [31:0]  angle_q8
);

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   logic [imutg_pkg::DVD_W-1:0]  dvd_ff, dvd_in;
   logic [imutg_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [imutg_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic                         neg_ff, neg_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic [15:0]                  mag;
   logic [35:0]                  prod;
   logic [imutg_pkg::DVD_W-1:0]  dvd, back;
   logic [imutg_pkg::EST_W-1:0]  est;
   logic signed [ACC_W:0]        qe, inc, sum, accx, rbias, rnd, rq;

   // Multiply on load; estimate, remainder and two corrections during run;
   // accumulate on commit.
   always_comb begin
      dvd_in = dvd_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      acc_in = acc_ff;
      mag    = rate[15] ? 16'(-rate) : 16'(rate);
      prod   = 36'(mag) * 36'(dt);
      dvd    = {prod, 9'b0} + imutg_pkg::GYRO_ROUND;
      est    = imutg_pkg::EST_W'(dvd_ff[imutg_pkg::DVD_W-1:imutg_pkg::DVD_LOW]) *
               imutg_pkg::EST_W'(imutg_pkg::GYRO_RECIP);
      back   = dvd_ff - (imutg_pkg::DVD_W'(quo_ff) * imutg_pkg::DVD_W'(imutg_pkg::GYRO_DIVISOR));
      qe     = $signed((ACC_W+1)'(quo_ff));
      inc    = neg_ff ? -qe : qe;
      sum    = {acc_ff[ACC_W-1], acc_ff} + inc;
      if (ctl.load) begin
         dvd_in = dvd;
         neg_in = rate[15];
      end else if (ctl.run) begin
         case (ctl.iter)
            imutg_pkg::DIV_ESTIMATE: begin
               quo_in = est[imutg_pkg::EST_SHIFT +: imutg_pkg::QUO_W];
            end
            imutg_pkg::DIV_REMAINDER: begin
               rem_in = back[imutg_pkg::REM_W-1:0];
            end
            imutg_pkg::DIV_FIX_A, imutg_pkg::DIV_FIX_B: begin
               if (rem_ff >= imutg_pkg::REM_W'(imutg_pkg::GYRO_DIVISOR)) begin
                  quo_in = quo_ff + imutg_pkg::QUO_W'(1);
                  rem_in = rem_ff - imutg_pkg::REM_W'(imutg_pkg::GYRO_DIVISOR);
               end
            end
            default: begin
            end
         endcase
      end else if (ctl.commit) begin
         if (sum[ACC_W] != sum[ACC_W-1]) begin
            acc_in = sum[ACC_W] ? ACC_MIN : ACC_MAX;
         end else begin
            acc_in = sum[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // Round Q16 to Q8 half away from zero, then saturate to 32 bits.
   always_comb begin
      accx  = {acc_ff[ACC_W-1], acc_ff};
      rbias = acc_ff[ACC_W-1] ? (ACC_W+1)'(127) : (ACC_W+1)'(128);
      rnd   = accx + rbias;
      rq    = rnd >>> 8;
      if (!rq[ACC_W] && (|rq[ACC_W-1:31])) begin
         angle_q8 = 32'sh7fffffff;
      end else if (rq[ACC_W] && !(&rq[ACC_W-1:31])) begin
         angle_q8 = 32'sh80000000;
      end else begin
         angle_q8 = rq[31:0];
      end
   end

endmodule

// ===== hw/rtl/imutg_back.sv =====
// ----------------------------------------------------------------------------
// imutg_back
// Back end: takes one queued sample at a time, sequences the CORDIC and gyro
// units and holds the result item in an output register.
// ----------------------------------------------------------------------------
module imutg_back #(
   parameter int CORDIC_STEPS      = 16,
   parameter int ACCUMULATOR_WIDTH = 48
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  imutg_pkg::sample_type head_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [16:0]    rsp_roll_from_accel,
   output logic signed [16:0]    rsp_pitch_from_accel,
   output logic signed [31:0]    rsp_roll_from_gyro,
   output logic signed [31:0]    rsp_pitch_from_gyro,
   output logic signed [31:0]    rsp_yaw_from_gyro
);

   localparam int STEPS_EFF = (CORDIC_STEPS > imutg_pkg::ANGLE_TABLE_LEN) ?
                              imutg_pkg::ANGLE_TABLE_LEN : CORDIC_STEPS;
   localparam int RUN_LEN   = (STEPS_EFF > imutg_pkg::DIV_STEPS) ?
                              STEPS_EFF : imutg_pkg::DIV_STEPS;

   imutg_pkg::st_type              st_ff, st_in;
   logic [imutg_pkg::ITER_W-1:0]   cnt_ff, cnt_in;
   imutg_pkg::ctl_type             ctl;
   logic                           out_load;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [16:0]             roll_a_ff, pitch_a_ff, roll_a, pitch_a;
   logic signed [31:0]             roll_g_ff, pitch_g_ff, yaw_g_ff, roll_g, pitch_g, yaw_g;
   logic signed [16:0]             pitch_y;

   // Sequencer: load, iterate, commit, hand over to the output register.
   always_comb begin
      st_in    = st_ff;
      cnt_in   = cnt_ff;
      pop      = 1'b0;
      out_load = 1'b0;
      case (st_ff)
         imutg_pkg::ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cnt_in = '0;
               st_in  = imutg_pkg::ST_RUN;
            end
         end
         imutg_pkg::ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == imutg_pkg::ITER_W'(RUN_LEN - 1)) begin
               st_in = imutg_pkg::ST_COMMIT;
            end
         end
         imutg_pkg::ST_COMMIT: begin
            st_in = imutg_pkg::ST_DONE;
         end
         imutg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               st_in    = imutg_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = imutg_pkg::ST_IDLE;
         end
      endcase
      ctl.load     = pop;
      ctl.run      = (st_ff == imutg_pkg::ST_RUN);
      ctl.iter     = cnt_ff;
      ctl.commit   = (st_ff == imutg_pkg::ST_COMMIT);
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= imutg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (out_load) begin
         roll_a_ff  <= roll_a;
         pitch_a_ff <= pitch_a;
         roll_g_ff  <= roll_g;
         pitch_g_ff <= pitch_g;
         yaw_g_ff   <= yaw_g;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_roll_from_accel  = roll_a_ff;
   assign rsp_pitch_from_accel = pitch_a_ff;
   assign rsp_roll_from_gyro   = roll_g_ff;
   assign rsp_pitch_from_gyro  = pitch_g_ff;
   assign rsp_yaw_from_gyro    = yaw_g_ff;

   // Pitch uses the negated X axis as its y operand.
   assign pitch_y = -{head_item.accel_x[15], head_item.accel_x};

   imutg_cordic #(.STEPS(CORDIC_STEPS)) u_roll_cordic (
      .clock (clock),
      .ctl   (ctl),
      .opd_y ({head_item.accel_y[15], head_item.accel_y}),
      .opd_x (head_item.accel_z),
      .angle (roll_a)
   );

   imutg_cordic #(.STEPS(CORDIC_STEPS)) u_pitch_cordic (
      .clock (clock),
      .ctl   (ctl),
      .opd_y (pitch_y),
      .opd_x (head_item.accel_z),
      .angle (pitch_a)
   );

   imutg_gyro #(.ACC_W(ACCUMULATOR_WIDTH)) u_roll_gyro (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rate     (head_item.gyro_x),
      .dt       (head_item.dt_us),
      .angle_q8 (roll_g)
   );

   imutg_gyro #(.ACC_W(ACCUMULATOR_WIDTH)) u_pitch_gyro (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rate     (head_item.gyro_y),
      .dt       (head_item.dt_us),
      .angle_q8 (pitch_g)
   );

   imutg_gyro #(.ACC_W(ACCUMULATOR_WIDTH)) u_yaw_gyro (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .rate     (head_item.gyro_z),
      .dt       (head_item.dt_us),
      .angle_q8 (yaw_g)
   );

endmodule

// ===== hw/rtl/imu_tilt_and_gyro_angle_integrator_top.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_and_gyro_angle_integrator_top
// Accelerometer tilt (roll, pitch) by CORDIC atan2 and integrated gyro angles.
//
//   channel  direction  handshake              payload
//   req_     in         req_valid/req_ready    accel x/y/z, gyro x/y/z, dt_us
//   rsp_     out        rsp_valid/rsp_ready    roll/pitch from accel, 3 gyro angles
//
// In the back end the run phase serves both the CORDIC rotation loop, capped
// at the arctangent table length, and the gyro divider steps, side by side.
// A two-entry queue takes new items while the back end works; the output
// register holds a result until it is taken, stalling the back end only then.
// Synchronous reset clears the queue, sequencer and the three accumulators.
// ----------------------------------------------------------------------------
module imu_tilt_and_gyro_angle_integrator_top #(
   parameter int CORDIC_STEPS      = 16,
   parameter int ACCUMULATOR_WIDTH = 48
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_accel_x,
   input  logic signed [15:0] req_accel_y,
   input  logic signed [15:0] req_accel_z,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic [19:0]        req_dt_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_roll_from_accel,
   output logic signed [16:0] rsp_pitch_from_accel,
   output logic signed [31:0] rsp_roll_from_gyro,
   output logic signed [31:0] rsp_pitch_from_gyro,
   output logic signed [31:0] rsp_yaw_from_gyro
);

   imutg_pkg::sample_type req_item, head_item;
   logic                  head_valid, pop;

   // Gather the input fields into one item.
   always_comb begin
      req_item.accel_x = req_accel_x;
      req_item.accel_y = req_accel_y;
      req_item.accel_z = req_accel_z;
      req_item.gyro_x  = req_gyro_x;
      req_item.gyro_y  = req_gyro_y;
      req_item.gyro_z  = req_gyro_z;
      req_item.dt_us   = req_dt_us;
   end

   imutg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   imutg_back #(
      .CORDIC_STEPS      (CORDIC_STEPS),
      .ACCUMULATOR_WIDTH (ACCUMULATOR_WIDTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head_item            (head_item),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_roll_from_accel  (rsp_roll_from_accel),
      .rsp_pitch_from_accel (rsp_pitch_from_accel),
      .rsp_roll_from_gyro   (rsp_roll_from_gyro),
      .rsp_pitch_from_gyro  (rsp_pitch_from_gyro),
      .rsp_yaw_from_gyro    (rsp_yaw_from_gyro)
   );

`ifndef NO_ASSERTIONS
   // The back end only takes an item that the queue holds.
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid) else $error("item taken from an empty queue");

   // One item at a time: never two takes in consecutive cycles.
   a_pop_spaced: assert property (@(posedge clock) disable iff (reset)
      pop |=> !pop) else $error("back end took items back to back");

   // After reset nothing is queued and no result is offered.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !head_valid && !rsp_valid) else $error("state left after reset");

   // The roll tilt angle stays within a half turn.
   a_tilt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_from_accel <= 17'sd46083 && rsp_roll_from_accel >= -17'sd46083)
      else $error("roll out of range");
`endif

endmodule

// ===== bench/imu_tilt_and_gyro_angle_integrator_top_tb.sv =====
// ----------------------------------------------------------------------------
// imu_tilt_and_gyro_angle_integrator_top_tb
// Self-checking bench: IMU samples go in through the request channel, and
// each result item is compared with a bit-exact prediction of the CORDIC
// tilt angles and the saturating gyro integrators.
// ----------------------------------------------------------------------------
module imu_tilt_and_gyro_angle_integrator_top_tb;

   localparam int CORDIC_STEPS = 16;
   localparam int ACC_W        = 48;
   localparam int N_RANDOM     = 1880;

   // Expected contents of one result item.
   typedef struct {
      logic signed [16:0] roll_acc;
      logic signed [16:0] pitch_acc;
      logic signed [31:0] roll_gyr;
      logic signed [31:0] pitch_gyr;
      logic signed [31:0] yaw_gyr;
   } attitude_type;

   // Scoreboard: predicts the attitude of each sample and checks the results.
   class attitude_scoreboard;
      longint roll_sum, pitch_sum, yaw_sum;
      attitude_type pending[$];
      int errors;
      int checked;

      function void clear();
         roll_sum = 0; pitch_sum = 0; yaw_sum = 0;
         pending.delete();
         errors = 0; checked = 0;
      endfunction

      // Arithmetic shift that floors.
      function longint floor_shr(longint v, int s);
         return v >>> s;
      endfunction

      function longint round_to_q8(longint v);
         longint m, r;
         m = (v < 0) ? -v : v;
         r = (m + 128) >> 8;
         return (v < 0) ? -r : r;
      endfunction

      function longint tilt_angle(longint y, longint x);
         longint ang, xs, ys, r;
         ang = 0;
         if (y == 0) return (x < 0) ? 46083 : 0;
         if (x < 0) begin
            ang = (y >= 0) ? 11797349 : -11797349;
            x = -x;
            y = -y;
         end
         x = x * 256;
         y = y * 256;
         for (int i = 0; i < CORDIC_STEPS && i < imutg_pkg::ANGLE_TABLE_LEN; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
               x = x + ys; y = y - xs;
               ang += longint'(imutg_pkg::angle_entry(i[imutg_pkg::ITER_W-1:0]));
            end else begin
               x = x - ys; y = y + xs;
               ang -= longint'(imutg_pkg::angle_entry(i[imutg_pkg::ITER_W-1:0]));
            end
         end
         r = round_to_q8(ang);
         if (r > 46083) r = 46083;
         if (r < -46083) r = -46083;
         return r;
      endfunction

      function longint integrate(longint acc, longint rate, longint dt);
         longint maxv, minv, p, m, q, inc;
         maxv = (longint'(1) <<< (ACC_W - 1)) - 1;
         minv = -maxv - 1;
         p = rate * dt * 512;
         m = (p < 0) ? -p : p;
         q = (m + 64062) / 128125;
         inc = (p < 0) ? -q : q;
         if (inc > 0 && acc > maxv - inc) return maxv;
         if (inc < 0 && acc < minv - inc) return minv;
         return acc + inc;
      endfunction

      function logic signed [31:0] gyro_angle(longint acc);
         longint r;
         r = round_to_q8(acc);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      // Notes an accepted sample and queues its expected attitude.
      function void note_sample(imutg_pkg::sample_type s);
         attitude_type e;
         roll_sum  = integrate(roll_sum, s.gyro_x, s.dt_us);
         pitch_sum = integrate(pitch_sum, s.gyro_y, s.dt_us);
         yaw_sum   = integrate(yaw_sum, s.gyro_z, s.dt_us);
         e.roll_acc  = tilt_angle(s.accel_y, s.accel_z);
         e.pitch_acc = tilt_angle(-longint'(s.accel_x), s.accel_z);
         e.roll_gyr  = gyro_angle(roll_sum);
         e.pitch_gyr = gyro_angle(pitch_sum);
         e.yaw_gyr   = gyro_angle(yaw_sum);
         pending.push_back(e);
      endfunction

      // Checks one accepted result against the oldest expectation.
      function void check_result(attitude_type a);
         attitude_type e;
         if (pending.size() == 0) begin
            $error("unexpected result item");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.roll_acc !== e.roll_acc) begin
            $error("roll_from_accel: expected %0d, got %0d", e.roll_acc, a.roll_acc);
            errors++;
         end
         if (a.pitch_acc !== e.pitch_acc) begin
            $error("pitch_from_accel: expected %0d, got %0d", e.pitch_acc, a.pitch_acc);
            errors++;
         end
         if (a.roll_gyr !== e.roll_gyr) begin
            $error("roll_from_gyro: expected %0d, got %0d", e.roll_gyr, a.roll_gyr);
            errors++;
         end
         if (a.pitch_gyr !== e.pitch_gyr) begin
            $error("pitch_from_gyro: expected %0d, got %0d", e.pitch_gyr, a.pitch_gyr);
            errors++;
         end
         if (a.yaw_gyr !== e.yaw_gyr) begin
            $error("yaw_from_gyro: expected %0d, got %0d", e.yaw_gyr, a.yaw_gyr);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   imutg_pkg::sample_type cur = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [16:0] rsp_roll_from_accel, rsp_pitch_from_accel;
   logic signed [31:0] rsp_roll_from_gyro, rsp_pitch_from_gyro, rsp_yaw_from_gyro;

   attitude_scoreboard board = new();
   bit hold_off = 1'b0;
   int saturated_seen = 0;

   always #10 clock = ~clock;

   imu_tilt_and_gyro_angle_integrator_top #(
      .CORDIC_STEPS(CORDIC_STEPS),
      .ACCUMULATOR_WIDTH(ACC_W)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_accel_x(cur.accel_x), .req_accel_y(cur.accel_y), .req_accel_z(cur.accel_z),
      .req_gyro_x(cur.gyro_x), .req_gyro_y(cur.gyro_y), .req_gyro_z(cur.gyro_z),
      .req_dt_us(cur.dt_us),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_roll_from_accel(rsp_roll_from_accel), .rsp_pitch_from_accel(rsp_pitch_from_accel),
      .rsp_roll_from_gyro(rsp_roll_from_gyro), .rsp_pitch_from_gyro(rsp_pitch_from_gyro),
      .rsp_yaw_from_gyro(rsp_yaw_from_gyro)
   );

   // Accepted items on both channels are seen at the rising edge.
   always @(posedge clock) begin
      attitude_type a;
      if (!reset && req_valid && req_ready) board.note_sample(cur);
      if (!reset && rsp_valid && rsp_ready) begin
         a.roll_acc = rsp_roll_from_accel;
         a.pitch_acc = rsp_pitch_from_accel;
         a.roll_gyr = rsp_roll_from_gyro;
         a.pitch_gyr = rsp_pitch_from_gyro;
         a.yaw_gyr = rsp_yaw_from_gyro;
         if (rsp_roll_from_gyro == 32'sh7fffffff || rsp_yaw_from_gyro == -32'sh80000000)
            saturated_seen++;
         board.check_result(a);
      end
   end

   // Receiver stall pattern: runs of ready and mostly not-ready, plus forced hold-off.
   initial begin
      int run_len;
      bit level;
      level = 1'b1;
      forever begin
         run_len = $urandom_range(1, 12);
         if ($urandom_range(0, 5) == 0) level = 1'b1;
         repeat (run_len) begin
            @(negedge clock);
            rsp_ready <= hold_off ? 1'b0 : (level ? 1'b1 : ($urandom_range(0, 3) == 0));
         end
         level = ~level;
      end
   end

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(0, 7))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sd0;
         3:       return $urandom_range(0, 8) - 4;
         default: return $urandom();
      endcase
   endfunction

   // Offers one sample and waits until it is taken.
   task automatic send_sample(imutg_pkg::sample_type s);
      req_valid <= 1'b1;
      cur <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_axes(int ax, int ay, int az, int gx, int gy, int gz, int dt);
      imutg_pkg::sample_type s;
      s.accel_x = ax; s.accel_y = ay; s.accel_z = az;
      s.gyro_x = gx; s.gyro_y = gy; s.gyro_z = gz;
      s.dt_us = dt;
      send_sample(s);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
   endtask

   // Stimulus.
   initial begin
      imutg_pkg::sample_type s;
      int burst;
      board.clear();
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero vector, axis cases, half turn and quadrant extremes.
      send_axes(0, 0, 0, 0, 0, 0, 0);
      send_axes(0, 0, -5, 0, 0, 0, 1);
      send_axes(0, 0, 100, 1, -1, 1, 1);
      send_axes(7, 7, 0, -32768, 32767, 0, 1048575);
      send_axes(-32768, 32767, -32768, 32767, -32768, 32767, 1048575);
      send_axes(32767, -32768, -32768, -32768, 32767, -32768, 1048575);
      send_axes(32767, 32767, 32767, 0, 0, 0, 0);
      send_axes(-32768, -32768, 32767, 0, 0, 0, 0);
      send_axes(1, -1, -32768, 0, 0, 0, 0);
      send_axes(-1, 1, -1, 0, 0, 0, 0);
      send_axes(-1, -1, -1, 0, 0, 0, 0);
      send_axes(0, 1, -32768, 12345, -12345, 1, 524288);
      send_axes(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 20'haaaaa);
      send_axes(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 20'h55555);
      wait_drained();

      // Drive all three integrators with full-scale rates at the longest dt, then reverse them.
      for (int k = 0; k < 9; k++)
         send_axes(100, 100, 100, 32767, -32768, -32768, 1048575);
      for (int k = 0; k < 3; k++)
         send_axes(-100, 100, -100, -32768, 32767, 32767, 1048575);

      // Long receiver hold-off while the sender keeps offering items.
      hold_off = 1'b1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end
         for (int k = 0; k < 8; k++) begin
            s = {pick_axis(), pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                 pick_axis(), 20'($urandom())};
            send_sample(s);
         end
      join
      wait_drained();

      // Random bursts with gaps; around item 900 the paused sender waits for every result.
      for (int n = 0; n < N_RANDOM; ) begin
         burst = $urandom_range(1, 30);
         for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
            s.accel_x = pick_axis();
            s.accel_y = pick_axis();
            s.accel_z = pick_axis();
            s.gyro_x = pick_axis();
            s.gyro_y = pick_axis();
            s.gyro_z = pick_axis();
            case ($urandom_range(0, 3))
               0:       s.dt_us = $urandom_range(0, 1) ? 20'hfffff : 20'd0;
               1:       s.dt_us = $urandom_range(500, 20000);
               default: s.dt_us = $urandom();
            endcase
            send_sample(s);
         end
         if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 40));
         if (n > 900 && n < 935) wait_drained();
      end
      wait_drained();
      repeat (40) @(negedge clock);

      $display("Checked %0d result items; %0d showed a gyro angle at its limit.",
               board.checked, saturated_seen);
      $display("Covered axis extremes, half turns, zero vectors and long stalls.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("** imu_tilt_and_gyro_angle_integrator_top: PASSED **");
      end else begin
         $display("** imu_tilt_and_gyro_angle_integrator_top: FAILED **");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20000000;
      $display("** imu_tilt_and_gyro_angle_integrator_top: FAILED **");
      $finish;
   end

endmodule
